@@ rtl/command_line_tokenizer_defines.svh @@
// Assertion macros shared by the tokenizer RTL.
// Expects i_clk and i_rst_n in the scope of the module that uses them.
`ifndef COMMAND_LINE_TOKENIZER_DEFINES_SVH
`define COMMAND_LINE_TOKENIZER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define CTKN_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define CTKN_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/ctkn_pkg.sv @@
// Types, limits and character codes for the command line tokenizer.
// Used by ctkn_front, ctkn_fifo, ctkn_back and the top level.
`default_nettype none

package ctkn_pkg;

    localparam int MAX_TOKENS      = 32;
    localparam int MAX_TOKEN_CHARS = 1024;

    // token count must hold MAX_TOKENS itself
    localparam int TK_W = $clog2(MAX_TOKENS + 1);
    // character count runs up to MAX_TOKEN_CHARS-1
    localparam int CN_W = $clog2(MAX_TOKEN_CHARS);

    localparam int RUN_MAX = 3;
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    typedef enum logic [2:0] {
        MODE_BETWEEN,
        MODE_SLASH,
        MODE_COMMENT,
        MODE_WORD,
        MODE_QUOTE
    } t_mode;

    typedef enum logic [1:0] {
        KIND_CHAR,
        KIND_END,
        KIND_LINE
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] ch;
        logic [4:0] idx;
        logic [5:0] total;
    } t_rec;

    // all results caused by one byte, in order, recs[0] first
    typedef struct packed {
        logic [1:0]              n;
        t_rec [RUN_MAX-1:0]      recs;
    } t_run;

    function automatic logic is_sep(input logic [7:0] c);
        return (c <= CH_SPACE) || c[7];
    endfunction

endpackage

`default_nettype wire

@@ rtl/ctkn_front.sv @@
// Front end: accepts text bytes, tracks scan mode and counters,
// and packs the results of each byte into one run. Uses ctkn_pkg.
`default_nettype none

module ctkn_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [7:0]    i_text_byte,
    input  wire logic          i_q_full,
    output logic               o_push,
    output ctkn_pkg::t_run     o_run
);
    import ctkn_pkg::*;

    `include "command_line_tokenizer_defines.svh"

    t_mode             r_mode, n_mode;
    logic [TK_W-1:0]   r_tk, n_tk;
    logic [CN_W-1:0]   r_cn, n_cn;

    logic              accept;
    logic              kept;
    logic              f_slash, f_char, f_end, f_line, f_start;
    t_mode             dec_mode;
    t_run              run;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign kept    = r_tk < TK_W'(MAX_TOKENS);

    // decode: which actions this byte takes, and the mode it leaves
    always_comb begin
        f_slash  = 1'b0;
        f_char   = 1'b0;
        f_end    = 1'b0;
        f_line   = 1'b0;
        f_start  = 1'b0;
        dec_mode = r_mode;
        unique case (r_mode)
            MODE_SLASH: begin
                if (i_text_byte == CH_SLASH) begin
                    dec_mode = MODE_COMMENT;
                end else begin
                    // held slash becomes the first word character
                    f_slash  = 1'b1;
                    dec_mode = MODE_WORD;
                    if (i_text_byte == CH_NUL) begin
                        f_end  = 1'b1;
                        f_line = 1'b1;
                    end else if (is_sep(i_text_byte)) begin
                        f_end = 1'b1;
                    end else begin
                        f_char = 1'b1;
                    end
                end
            end
            MODE_COMMENT: begin
                if (i_text_byte == CH_NUL) begin
                    f_line = 1'b1;
                end else if (i_text_byte == CH_NL) begin
                    dec_mode = MODE_BETWEEN;
                end
            end
            MODE_WORD: begin
                if (i_text_byte == CH_NUL) begin
                    f_end  = 1'b1;
                    f_line = 1'b1;
                end else if (is_sep(i_text_byte)) begin
                    f_end = 1'b1;
                end else begin
                    f_char = 1'b1;
                end
            end
            MODE_QUOTE: begin
                if (i_text_byte == CH_NUL) begin
                    f_end  = 1'b1;
                    f_line = 1'b1;
                end else if (i_text_byte == CH_QUOTE) begin
                    f_end = 1'b1;
                end else begin
                    f_char = 1'b1;
                end
            end
            default: begin
                if (i_text_byte == CH_NUL) begin
                    f_line = 1'b1;
                end else if (is_sep(i_text_byte)) begin
                    dec_mode = MODE_BETWEEN;
                end else if (i_text_byte == CH_SLASH) begin
                    f_start  = 1'b1;
                    dec_mode = MODE_SLASH;
                end else if (i_text_byte == CH_QUOTE) begin
                    f_start  = 1'b1;
                    dec_mode = MODE_QUOTE;
                end else begin
                    f_start  = 1'b1;
                    f_char   = 1'b1;
                    dec_mode = MODE_WORD;
                end
            end
        endcase
    end

    // build the run in fixed order: slash, character, token end, line end
    always_comb begin
        logic [1:0]      slot;
        logic [CN_W-1:0] cn_v;
        logic [TK_W-1:0] tk_v;
        run  = '0;
        slot = 2'd0;
        cn_v = f_start ? '0 : r_cn;
        tk_v = r_tk;
        if (f_slash && kept && cn_v < CN_W'(MAX_TOKEN_CHARS - 1)) begin
            run.recs[slot] = '{kind: KIND_CHAR, ch: CH_SLASH,
                               idx: 5'(tk_v), total: 6'(tk_v)};
            slot = slot + 2'd1;
            cn_v = cn_v + 1'b1;
        end
        if (f_char && kept && cn_v < CN_W'(MAX_TOKEN_CHARS - 1)) begin
            run.recs[slot] = '{kind: KIND_CHAR, ch: i_text_byte,
                               idx: 5'(tk_v), total: 6'(tk_v)};
            slot = slot + 2'd1;
            cn_v = cn_v + 1'b1;
        end
        if (f_end && kept) begin
            tk_v = tk_v + 1'b1;
            run.recs[slot] = '{kind: KIND_END, ch: CH_NUL,
                               idx: 5'(r_tk), total: 6'(tk_v)};
            slot = slot + 2'd1;
        end
        if (f_line) begin
            run.recs[slot] = '{kind: KIND_LINE, ch: CH_NUL,
                               idx: 5'd0, total: 6'(tk_v)};
            slot = slot + 2'd1;
            tk_v = '0;
        end
        run.n  = slot;
        n_mode = (f_end || f_line) ? MODE_BETWEEN : dec_mode;
        n_tk   = tk_v;
        n_cn   = (f_end || f_line) ? '0 : cn_v;
    end

    assign o_run  = run;
    assign o_push = accept && (run.n != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_BETWEEN;
            r_tk   <= '0;
            r_cn   <= '0;
        end else if (accept) begin
            r_mode <= n_mode;
            r_tk   <= n_tk;
            r_cn   <= n_cn;
        end
    end

    `CTKN_ASSERT_NOW(a_tk_bound, 1'b1, r_tk <= TK_W'(MAX_TOKENS), "token count past limit")
    `CTKN_ASSERT_NOW(a_cn_idle, r_mode == MODE_BETWEEN || r_mode == MODE_COMMENT,
                     r_cn == '0, "char count not clear outside a token")

endmodule

`default_nettype wire

@@ rtl/ctkn_fifo.sv @@
// Short run queue between front and back end.
// Flop storage, one write and one head read per cycle. Uses ctkn_pkg.
`default_nettype none

module ctkn_fifo (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire ctkn_pkg::t_run  i_run,
    output logic                 o_full,
    input  wire logic            i_pop,
    output logic                 o_valid,
    output ctkn_pkg::t_run       o_run
);
    import ctkn_pkg::*;

    `include "command_line_tokenizer_defines.svh"

    t_run              r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr, r_rd;
    logic [Q_AW:0]     r_count, n_count;

    assign o_full  = r_count == (Q_AW + 1)'(Q_DEPTH);
    assign o_valid = r_count != '0;
    assign o_run   = r_mem[r_rd];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= n_count;
        end
    end

    `CTKN_ASSERT_NOW(a_no_overflow, o_full, !i_push, "push into full queue")
    `CTKN_ASSERT_NOW(a_no_underflow, !o_valid, !i_pop, "pop from empty queue")

endmodule

`default_nettype wire

@@ rtl/ctkn_back.sv @@
// Back end: takes one run at a time from the queue and hands out its
// results one per cycle while i_ready is high, marking the last. Uses ctkn_pkg.
`default_nettype none

module ctkn_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_q_valid,
    input  wire ctkn_pkg::t_run  i_q_run,
    output logic                 o_pop,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output ctkn_pkg::t_rec       o_rec,
    output logic                 o_last
);
    import ctkn_pkg::*;

    `include "command_line_tokenizer_defines.svh"

    t_run        r_run;
    logic        r_have;
    logic [1:0]  r_sub;
    logic        fire;
    logic        load;

    assign o_valid = r_have;
    assign o_rec   = r_run.recs[r_sub];
    assign o_last  = r_sub == (r_run.n - 2'd1);
    assign fire    = r_have && i_ready;
    // refill when empty, or as the last result of the held run leaves
    assign load    = i_q_valid && (!r_have || (fire && o_last));
    assign o_pop   = load;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_run <= i_q_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
            r_sub  <= '0;
        end else if (load) begin
            r_have <= 1'b1;
            r_sub  <= '0;
        end else if (fire && o_last) begin
            r_have <= 1'b0;
            r_sub  <= '0;
        end else if (fire) begin
            r_sub <= r_sub + 2'd1;
        end
    end

    `CTKN_ASSERT_NOW(a_run_nonempty, r_have, r_run.n != 2'd0, "empty run held")
    `CTKN_ASSERT_NOW(a_sub_in_run, r_have, r_sub < r_run.n, "result index past run")
    `CTKN_ASSERT_NEXT(a_line_clears, fire && o_rec.kind == KIND_LINE, !r_have || r_sub == 2'd0,
                      "line end not last of its run")

endmodule

`default_nettype wire

@@ rtl/command_line_tokenizer.sv @@
// Top level of the command line tokenizer: front end, run queue, back end.
// Depends on ctkn_pkg, ctkn_front, ctkn_fifo and ctkn_back.
//
//   channel   direction  handshake          payload
//   text in   input      i_valid/o_ready    i_text_byte
//   results   output     o_valid/i_ready    o_kind, o_token_char, o_arg_index,
//                                           o_arg_total, o_last_of_run
//
// One text byte is taken per cycle while the four-entry run queue has room.
// Each byte yields zero to three results, sent one per cycle by the back end
// while i_ready is high, so the output port sets the sustained rate on busy
// lines. A result is registered in the run queue, then in the back end.
// Synchronous active-low reset returns the scanner to between tokens, zero
// counts, empty queue. Output stalls back up through the queue to o_ready.
`default_nettype none

module command_line_tokenizer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_text_byte,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_token_char,
    output logic [4:0]       o_arg_index,
    output logic [5:0]       o_arg_total,
    output logic             o_last_of_run
);
    import ctkn_pkg::*;

    logic  q_full, q_push, q_pop, q_valid;
    t_run  front_run, head_run;
    t_rec  rec;

    ctkn_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_text_byte (i_text_byte),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_run       (front_run)
    );

    ctkn_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_run   (front_run),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_run   (head_run)
    );

    ctkn_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_run   (head_run),
        .o_pop     (q_pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_rec     (rec),
        .o_last    (o_last_of_run)
    );

    assign o_kind       = rec.kind;
    assign o_token_char = rec.ch;
    assign o_arg_index  = rec.idx;
    assign o_arg_total  = rec.total;

endmodule

`default_nettype wire
